FILE: rtl/core/qmn_pkg.sv
// Shared constants and width helpers for the normalized quaternion product block.
package qmn_pkg;

    localparam int COMPONENT_WIDTH = 16;

    // Width of a product magnitude after it is reduced below 2^31.
    function automatic int qmn_mag_width(input int w);
        return (2 * w > 31) ? 31 : 2 * w;
    endfunction

    // Width of the right-shift amount that brings the largest magnitude below 2^31.
    function automatic int qmn_shift_width(input int w);
        return $clog2(2 * w + 1);
    endfunction

endpackage

FILE: rtl/core/qmn_in_if.sv
// Input channel: two quaternions with a valid/ready handshake.
interface qmn_in_if
    import qmn_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] b_w;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;

    modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
    modport sink (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

FILE: rtl/core/qmn_out_if.sv
// Output channel: normalized quaternion and zero flag with a valid/ready handshake.
interface qmn_out_if
    import qmn_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r_w;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic signed [W-1:0] r_z;
    logic                zero_norm;

    modport source (output valid, r_w, r_x, r_y, r_z, zero_norm, input ready);
    modport sink (input valid, r_w, r_x, r_y, r_z, zero_norm, output ready);
endinterface

FILE: rtl/core/qmn_product.sv
// Two-stage exact quaternion product: sixteen multiplies, then four signed sums.
module qmn_product
    import qmn_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH,
    localparam int PW = 2 * W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [W-1:0]  i_a [4],
    input  logic signed [W-1:0]  i_b [4],
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [PW-1:0] o_p [4]
);

    logic                  r_v1, r_v2;
    logic                  en1, en2;
    logic signed [2*W-1:0] r_prod [16];
    logic signed [2*W-1:0] n_prod [16];
    logic signed [PW-1:0]  e [16];
    logic signed [PW-1:0]  r_p [4];

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_p     = r_p;

    // Index order is w, x, y, z for both operands.
    always_comb begin
        n_prod[0]  = i_a[0] * i_b[0];
        n_prod[1]  = i_a[1] * i_b[1];
        n_prod[2]  = i_a[2] * i_b[2];
        n_prod[3]  = i_a[3] * i_b[3];
        n_prod[4]  = i_a[1] * i_b[0];
        n_prod[5]  = i_a[0] * i_b[1];
        n_prod[6]  = i_a[3] * i_b[2];
        n_prod[7]  = i_a[2] * i_b[3];
        n_prod[8]  = i_a[2] * i_b[0];
        n_prod[9]  = i_a[0] * i_b[2];
        n_prod[10] = i_a[1] * i_b[3];
        n_prod[11] = i_a[3] * i_b[1];
        n_prod[12] = i_a[3] * i_b[0];
        n_prod[13] = i_a[0] * i_b[3];
        n_prod[14] = i_a[2] * i_b[1];
        n_prod[15] = i_a[1] * i_b[2];
    end

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            e[j] = PW'(r_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_prod <= n_prod;
        end
        if (en2) begin
            r_p[0] <= e[0] - e[1] - e[2] - e[3];
            r_p[1] <= e[4] + e[5] + e[6] - e[7];
            r_p[2] <= e[8] + e[9] + e[10] - e[11];
            r_p[3] <= e[12] + e[13] + e[14] - e[15];
        end
    end

endmodule

FILE: rtl/core/qmn_reduce.sv
// Magnitudes, common reduction shift, squares and their sum over five stages.
module qmn_reduce
    import qmn_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH,
    localparam int PW = 2 * W + 1,
    localparam int MW = qmn_mag_width(W),
    localparam int QW = 2 * MW,
    localparam int SW = QW + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [PW-1:0] i_p [4],
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SW-1:0]        o_s,
    output logic [QW-1:0]        o_sq [4],
    output logic [3:0]           o_neg,
    output logic                 o_zero
);

    localparam int MAGW = 2 * W;
    localparam int KW   = qmn_shift_width(W);
    localparam int NST  = 5;

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST:0]   en;

    logic [MAGW-1:0] r_mag1 [4];
    logic [MAGW-1:0] r_or1;
    logic [MAGW-1:0] n_mag [4];
    logic [MAGW-1:0] n_or;
    logic [MAGW-1:0] r_mag2 [4];
    logic [KW-1:0]   r_k2;
    logic [KW-1:0]   n_k;
    logic [MW-1:0]   r_m3 [4];
    logic [QW-1:0]   r_sq4 [4];
    logic [QW-1:0]   r_sq5 [4];
    logic [SW-1:0]   r_s5;
    logic [3:0]      r_neg [NST];
    logic [NST-1:0]  r_zero;
    logic [PW-1:0]   abs_p [4];

    always_comb begin
        en[NST] = i_ready;
        for (int s = NST - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign n_v     = {r_v[NST-2:0], i_valid};
    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_s     = r_s5;
    assign o_sq    = r_sq5;
    assign o_neg   = r_neg[NST-1];
    assign o_zero  = r_zero[NST-1];

    always_comb begin
        n_or = '0;
        for (int l = 0; l < 4; l++) begin
            abs_p[l] = i_p[l][PW-1] ? PW'(-i_p[l]) : PW'(i_p[l]);
            n_mag[l] = abs_p[l][MAGW-1:0];
            n_or     = n_or | n_mag[l];
        end
    end

    // Smallest right shift that brings the largest magnitude below 2^31.
    always_comb begin
        n_k = '0;
        for (int j = MW; j < MAGW; j++) begin
            if (r_or1[j]) n_k = KW'(j - MW + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (en[s]) r_v[s] <= n_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_mag1    <= n_mag;
            r_or1     <= n_or;
            r_zero[0] <= (n_or == '0);
            for (int l = 0; l < 4; l++) begin
                r_neg[0][l] <= i_p[l][PW-1];
            end
        end
        if (en[1]) begin
            r_mag2    <= r_mag1;
            r_k2      <= n_k;
            r_neg[1]  <= r_neg[0];
            r_zero[1] <= r_zero[0];
        end
        if (en[2]) begin
            for (int l = 0; l < 4; l++) begin
                r_m3[l] <= MW'(r_mag2[l] >> r_k2);
            end
            r_neg[2]  <= r_neg[1];
            r_zero[2] <= r_zero[1];
        end
        if (en[3]) begin
            for (int l = 0; l < 4; l++) begin
                r_sq4[l] <= QW'(r_m3[l]) * QW'(r_m3[l]);
            end
            r_neg[3]  <= r_neg[2];
            r_zero[3] <= r_zero[2];
        end
        if (en[4]) begin
            r_sq5     <= r_sq4;
            r_s5      <= SW'(r_sq4[0]) + SW'(r_sq4[1]) + SW'(r_sq4[2]) + SW'(r_sq4[3]);
            r_neg[4]  <= r_neg[3];
            r_zero[4] <= r_zero[3];
        end
    end

endmodule

FILE: rtl/core/qmn_search.sv
// Bit-per-stage search for the rounded normalized magnitude of each component.
module qmn_search
    import qmn_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH,
    localparam int MW = qmn_mag_width(W),
    localparam int QW = 2 * MW,
    localparam int SW = QW + 2,
    localparam int NW = W - 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [SW-1:0] i_s,
    input  logic [QW-1:0] i_sq [4],
    input  logic [3:0]    i_neg,
    input  logic          i_zero,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [NW-1:0] o_n [4],
    output logic [3:0]    o_neg,
    output logic          o_zero
);

    localparam int NS = W - 1;
    localparam int EW = 2 * W + SW + 3;

    // Per lane: n so far, E = (2n-1)^2 * S and F = (2n-1) * S.
    logic [NS-1:0]        r_v;
    logic [NS:0]          en;
    logic                 c_v [NS];
    logic [SW-1:0]        c_s [NS];
    logic [QW-1:0]        c_sq [NS][4];
    logic [3:0]           c_neg [NS];
    logic                 c_zero [NS];
    logic [NW-1:0]        c_n [NS][4];
    logic signed [EW-1:0] c_e [NS][4];
    logic signed [EW-1:0] c_f [NS][4];

    logic [SW-1:0]        r_s [NS];
    logic [QW-1:0]        r_sq [NS][4];
    logic [3:0]           r_neg [NS];
    logic                 r_zero [NS];
    logic [NW-1:0]        r_n [NS][4];
    logic signed [EW-1:0] r_e [NS][4];
    logic signed [EW-1:0] r_f [NS][4];

    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_n     = r_n[NS-1];
    assign o_neg   = r_neg[NS-1];
    assign o_zero  = r_zero[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (en[s]) r_v[s] <= c_v[s];
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int J = W - 2 - s;

        logic signed [EW-1:0] s_ext;
        logic signed [EW-1:0] f_try [4];
        logic signed [EW-1:0] e_try [4];
        logic signed [EW-1:0] t_lim [4];
        logic [3:0]           pass;

        if (s == 0) begin : g_first
            assign c_v[s]    = i_valid;
            assign c_s[s]    = i_s;
            assign c_neg[s]  = i_neg;
            assign c_zero[s] = i_zero;
            for (genvar l = 0; l < 4; l++) begin : g_lane
                assign c_sq[s][l] = i_sq[l];
                assign c_n[s][l]  = '0;
                assign c_e[s][l]  = $signed(EW'(i_s));
                assign c_f[s][l]  = -$signed(EW'(i_s));
            end
        end else begin : g_next
            assign c_v[s]    = r_v[s-1];
            assign c_s[s]    = r_s[s-1];
            assign c_neg[s]  = r_neg[s-1];
            assign c_zero[s] = r_zero[s-1];
            for (genvar l = 0; l < 4; l++) begin : g_lane
                assign c_sq[s][l] = r_sq[s-1][l];
                assign c_n[s][l]  = r_n[s-1][l];
                assign c_e[s][l]  = r_e[s-1][l];
                assign c_f[s][l]  = r_f[s-1][l];
            end
        end

        assign s_ext = $signed(EW'(c_s[s]));

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                f_try[l] = c_f[s][l] + (s_ext <<< (J + 1));
                e_try[l] = c_e[s][l] + (c_f[s][l] <<< (J + 2)) + (s_ext <<< (2 * J + 2));
                t_lim[l] = $signed(EW'(c_sq[s][l]) << (2 * W - 2));
                pass[l]  = (e_try[l] <= t_lim[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_s[s]    <= c_s[s];
                r_sq[s]   <= c_sq[s];
                r_neg[s]  <= c_neg[s];
                r_zero[s] <= c_zero[s];
                for (int l = 0; l < 4; l++) begin
                    if (pass[l]) begin
                        r_n[s][l] <= c_n[s][l] | (NW'(1) << J);
                        r_e[s][l] <= e_try[l];
                        r_f[s][l] <= f_try[l];
                    end else begin
                        r_n[s][l] <= c_n[s][l];
                        r_e[s][l] <= c_e[s][l];
                        r_f[s][l] <= c_f[s][l];
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/core/quaternion_multiply_normalize.sv
// Pipelined quaternion product with exact fixed-point normalization to unit length.
//
// Each transfer on i_qin carries two quaternions in signed Q2.(W-2); the block returns
// their product scaled to unit length, each component rounded to nearest (ties away from
// zero) and held within plus or minus 1.0, with zero_norm set and all components zero
// when the product vanishes. The pipeline takes one transfer every cycle unless a stall
// backs up to its input, and returns one result per transfer in order. Its stages are
// two for the sixteen multiplies and the four sums, five for the magnitudes, the common
// shift that keeps the largest below 2^31, the squares and their sum, one per result bit
// (W - 1, W being the component width) for the compare-based rounding search, and one
// output register. Every stage has its own valid bit and moves on whenever the stage
// after it is empty or moving, so a stalled output only holds the stages that are full.
module quaternion_multiply_normalize
    import qmn_pkg::*;
#(
    parameter int COMPONENT_WIDTH_P = COMPONENT_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qmn_in_if.sink   i_qin,
    qmn_out_if.source o_qout
);

    localparam int W  = COMPONENT_WIDTH_P;
    localparam int PW = 2 * W + 1;
    localparam int MW = qmn_mag_width(W);
    localparam int QW = 2 * MW;
    localparam int SW = QW + 2;
    localparam int NW = W - 1;

    logic signed [W-1:0]  in_a [4];
    logic signed [W-1:0]  in_b [4];

    logic                 prod_valid, prod_ready;
    logic signed [PW-1:0] prod_p [4];

    logic                 red_valid, red_ready;
    logic [SW-1:0]        red_s;
    logic [QW-1:0]        red_sq [4];
    logic [3:0]           red_neg;
    logic                 red_zero;

    logic                 srch_valid;
    logic [NW-1:0]        srch_n [4];
    logic [3:0]           srch_neg;
    logic                 srch_zero;

    logic                 out_en;
    logic                 r_out_v;
    logic signed [W-1:0]  r_res [4];
    logic signed [W-1:0]  n_res [4];
    logic                 r_zero;

    assign in_a[0] = i_qin.a_w;
    assign in_a[1] = i_qin.a_x;
    assign in_a[2] = i_qin.a_y;
    assign in_a[3] = i_qin.a_z;
    assign in_b[0] = i_qin.b_w;
    assign in_b[1] = i_qin.b_x;
    assign in_b[2] = i_qin.b_y;
    assign in_b[3] = i_qin.b_z;

    qmn_product #(.W(W)) u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_qin.valid),
        .o_ready (i_qin.ready),
        .i_a     (in_a),
        .i_b     (in_b),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_p     (prod_p)
    );

    qmn_reduce #(.W(W)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_p     (prod_p),
        .o_valid (red_valid),
        .i_ready (red_ready),
        .o_s     (red_s),
        .o_sq    (red_sq),
        .o_neg   (red_neg),
        .o_zero  (red_zero)
    );

    qmn_search #(.W(W)) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (red_valid),
        .o_ready (red_ready),
        .i_s     (red_s),
        .i_sq    (red_sq),
        .i_neg   (red_neg),
        .i_zero  (red_zero),
        .o_valid (srch_valid),
        .i_ready (out_en),
        .o_n     (srch_n),
        .o_neg   (srch_neg),
        .o_zero  (srch_zero)
    );

    // The output register takes a new result when it is empty or its result is taken.
    assign out_en = !r_out_v || o_qout.ready;

    // Apply the sign; a zero product forces all components to zero.
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (srch_zero) begin
                n_res[l] = '0;
            end else if (srch_neg[l]) begin
                n_res[l] = -$signed(W'(srch_n[l]));
            end else begin
                n_res[l] = $signed(W'(srch_n[l]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= srch_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_res  <= n_res;
            r_zero <= srch_zero;
        end
    end

    assign o_qout.valid     = r_out_v;
    assign o_qout.r_w       = r_res[0];
    assign o_qout.r_x       = r_res[1];
    assign o_qout.r_y       = r_res[2];
    assign o_qout.r_z       = r_res[3];
    assign o_qout.zero_norm = r_zero;

endmodule

FILE: test/qmn_tb_pkg.sv
// Shared testbench types for the normalized quaternion product checks.
package qmn_tb_pkg;
    import qmn_pkg::*;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

    // One pair of quaternions offered to the block.
    typedef struct packed {
        comp_t a_w, a_x, a_y, a_z;
        comp_t b_w, b_x, b_y, b_z;
    } qpair_t;

    // One normalized product returned by the block.
    typedef struct packed {
        comp_t r_w, r_x, r_y, r_z;
        logic  zero_norm;
    } unit_quat_t;
endpackage

FILE: test/testbench.sv
// Self-checking testbench for the normalized quaternion product pipeline.
module testbench;
    import qmn_pkg::*;
    import qmn_tb_pkg::*;

    localparam int W         = COMPONENT_WIDTH;
    localparam int LATENCY   = W + 7;
    localparam int MAX_CYCLE = 400000;
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

    // Idle modes for each phase of the run.
    typedef enum int { IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH } idle_mode_e;

    logic i_clk;
    logic i_rst_n;

    qmn_in_if  #(.W(W)) qin ();
    qmn_out_if #(.W(W)) qout ();

    quaternion_multiply_normalize u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_qin  (qin.sink),
        .o_qout (qout.source)
    );

    qpair_t     pending_pairs[$];
    unit_quat_t expected_units[$];
    idle_mode_e idle_mode;
    int         errors;
    int         cycles;
    int         sent_count;
    int         checked_count;
    int         zero_count;
    int         holdoff_left;
    logic       hold_sender;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Rounded magnitude: the largest n in 0..2^(W-2) with (2n-1)^2*S <= 2^(2W-2)*m^2.
    function automatic logic [63:0] rounded_scale(input logic [63:0] m, input logic [63:0] s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  d;
        rhs = (128'(m) * 128'(m)) << (2 * W - 2);
        lo  = 0;
        hi  = 64'd1 << (W - 2);
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d   = 2 * mid - 1;
            lhs = 128'(d * d) * 128'(s);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    // Exact Hamilton product, then normalization to unit length.
    function automatic unit_quat_t normalized_product(input qpair_t q);
        longint     prod[4];
        logic [63:0] mag[4];
        logic [63:0] top;
        logic [63:0] sum_sq;
        logic [63:0] n;
        int          sh;
        unit_quat_t  r;
        prod[0] = longint'(q.a_w) * q.b_w - longint'(q.a_x) * q.b_x
                - longint'(q.a_y) * q.b_y - longint'(q.a_z) * q.b_z;
        prod[1] = longint'(q.b_w) * q.a_x + longint'(q.b_x) * q.a_w
                + longint'(q.b_y) * q.a_z - longint'(q.b_z) * q.a_y;
        prod[2] = longint'(q.b_w) * q.a_y + longint'(q.b_y) * q.a_w
                + longint'(q.b_z) * q.a_x - longint'(q.b_x) * q.a_z;
        prod[3] = longint'(q.b_w) * q.a_z + longint'(q.b_z) * q.a_w
                + longint'(q.b_x) * q.a_y - longint'(q.b_y) * q.a_x;
        top = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = (prod[i] < 0) ? -prod[i] : prod[i];
            if (mag[i] > top) top = mag[i];
        end
        r = '0;
        if (top == 0) begin
            r.zero_norm = 1'b1;
            return r;
        end
        // Common shift keeps the largest magnitude below 2^31.
        sh = 0;
        while ((top >> sh) >= (64'd1 << 31)) sh++;
        sum_sq = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = mag[i] >> sh;
            sum_sq += mag[i] * mag[i];
        end
        for (int i = 0; i < 4; i++) begin
            n = rounded_scale(mag[i], sum_sq);
            if (prod[i] < 0) n = -n;
            case (i)
                0: r.r_w = n[W-1:0];
                1: r.r_x = n[W-1:0];
                2: r.r_y = n[W-1:0];
                default: r.r_z = n[W-1:0];
            endcase
        end
        return r;
    endfunction

    function automatic comp_t random_comp();
        case ($urandom_range(0, 9))
            0: return MINV;
            1: return MAXV;
            2: return comp_t'(16384);
            3: return comp_t'(-16384);
            4: return '0;
            5: return comp_t'($urandom_range(0, 15)) - comp_t'(8);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic qpair_t random_pair();
        qpair_t q;
        q = {random_comp(), random_comp(), random_comp(), random_comp(),
             random_comp(), random_comp(), random_comp(), random_comp()};
        // Now and then one operand is zero so that the product vanishes.
        if ($urandom_range(0, 19) == 0) q[8*W-1:4*W] = '0;
        else if ($urandom_range(0, 19) == 0) q[4*W-1:0] = '0;
        return q;
    endfunction

    // Driver: offers the head of the pending queue and retires it on a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            qin.valid <= 1'b0;
        end else begin
            if (qin.valid && qin.ready) begin
                expected_units.push_back(normalized_product(pending_pairs.pop_front()));
                sent_count++;
            end
            if (pending_pairs.size() > 0 && !hold_sender &&
                !((idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) &&
                  $urandom_range(0, 99) < ((idle_mode == IDLE_BOTH) ? 21 : 71))) begin
                {qin.a_w, qin.a_x, qin.a_y, qin.a_z, qin.b_w, qin.b_x, qin.b_y, qin.b_z}
                    <= pending_pairs[0];
                qin.valid <= 1'b1;
            end else begin
                // The offer stays put only if it has not just been taken.
                qin.valid <= qin.valid && !qin.ready;
            end
        end
    end

    // Monitor: compares each transfer on the output with the oldest expectation.
    always @(posedge i_clk) begin
        unit_quat_t want;
        if (!i_rst_n) begin
            qout.ready <= 1'b0;
        end else begin
            if (qout.valid && qout.ready) begin
                if (expected_units.size() == 0) begin
                    $error("result with no expectation waiting");
                    errors++;
                end else begin
                    want = expected_units.pop_front();
                    checked_count++;
                    if (want.zero_norm) zero_count++;
                    if (qout.r_w !== want.r_w) begin
                        $error("r_w expected %0d actual %0d", want.r_w, qout.r_w);
                        errors++;
                    end
                    if (qout.r_x !== want.r_x) begin
                        $error("r_x expected %0d actual %0d", want.r_x, qout.r_x);
                        errors++;
                    end
                    if (qout.r_y !== want.r_y) begin
                        $error("r_y expected %0d actual %0d", want.r_y, qout.r_y);
                        errors++;
                    end
                    if (qout.r_z !== want.r_z) begin
                        $error("r_z expected %0d actual %0d", want.r_z, qout.r_z);
                        errors++;
                    end
                    if (qout.zero_norm !== want.zero_norm) begin
                        $error("zero_norm expected %0d actual %0d",
                               want.zero_norm, qout.zero_norm);
                        errors++;
                    end
                end
            end
            // A long hold-off is counted down here; otherwise the idle mode decides.
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                qout.ready   <= 1'b0;
            end else begin
                qout.ready <= !((idle_mode == IDLE_SNK || idle_mode == IDLE_BOTH) &&
                                $urandom_range(0, 99) <
                                ((idle_mode == IDLE_BOTH) ? 21 : 71));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || qin.valid || expected_units.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input idle_mode_e mode, input int count);
        idle_mode = mode;
        for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
        wait_drained();
    endtask

    initial begin
        qpair_t q;
        errors = 0; cycles = 0; sent_count = 0; checked_count = 0; zero_count = 0;
        holdoff_left = 0; hold_sender = 1'b0; idle_mode = IDLE_NONE;
        i_rst_n = 1'b0;
        qin.valid = 1'b0; qout.ready = 1'b0;
        {qin.a_w, qin.a_x, qin.a_y, qin.a_z, qin.b_w, qin.b_x, qin.b_y, qin.b_z} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases: identity, zero product, extremes, single axes, small values.
        pending_pairs.push_back({comp_t'(16384), 48'd0, comp_t'(16384), 48'd0});
        pending_pairs.push_back('0);
        pending_pairs.push_back({comp_t'(16384), 48'd0, 64'd0});
        pending_pairs.push_back({{8{MINV}}});
        pending_pairs.push_back({{8{MAXV}}});
        pending_pairs.push_back({MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV});
        pending_pairs.push_back({MAXV, 48'd0, MINV, 48'd0});
        pending_pairs.push_back({16'd0, comp_t'(16384), 32'd0, 16'd0, comp_t'(16384), 32'd0});
        pending_pairs.push_back({32'd0, comp_t'(-16384), 16'd0, 48'd0, comp_t'(16384)});
        pending_pairs.push_back({comp_t'(1), 48'd0, comp_t'(1), 48'd0});
        pending_pairs.push_back({comp_t'(1), comp_t'(1), 32'd0, comp_t'(1), 48'd0});
        pending_pairs.push_back({comp_t'(-1), comp_t'(1), comp_t'(-1), comp_t'(1),
                                 comp_t'(1), 48'd0});
        pending_pairs.push_back({comp_t'(3), comp_t'(1), 32'd0, comp_t'(1), 48'd0});
        pending_pairs.push_back({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        pending_pairs.push_back({MINV, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV});
        wait_drained();

        run_phase(IDLE_NONE, 200);
        run_phase(IDLE_SRC, 120);
        run_phase(IDLE_SNK, 120);
        run_phase(IDLE_BOTH, 100);

        // The receiver holds off long enough to fill the pipeline while items keep coming.
        idle_mode = IDLE_NONE;
        @(posedge i_clk);
        holdoff_left <= 3 * LATENCY;
        for (int i = 0; i < 80; i++) pending_pairs.push_back(random_pair());
        wait_drained();

        // The sender pauses mid-stream until everything is back, then finishes the batch.
        for (int i = 0; i < 40; i++) pending_pairs.push_back(random_pair());
        repeat (10) @(posedge i_clk);
        hold_sender <= 1'b1;
        @(posedge i_clk);
        while (qin.valid || expected_units.size() > 0) @(posedge i_clk);
        hold_sender <= 1'b0;
        wait_drained();
        run_phase(IDLE_BOTH, 40);

        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Covered %0d transfers in, %0d results checked, %0d with zero magnitude.",
                 sent_count, checked_count, zero_count);
        $display("Phases ran with no idling, sender gaps, receiver stalls and both.");
        if (errors == 0 && expected_units.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/qmn_pkg.sv
rtl/core/qmn_in_if.sv
rtl/core/qmn_out_if.sv
rtl/core/qmn_product.sv
rtl/core/qmn_reduce.sv
rtl/core/qmn_search.sv
rtl/core/quaternion_multiply_normalize.sv
test/qmn_tb_pkg.sv
test/testbench.sv
